>>> rtl/core/ate_pkg.sv
// Shared types and constants for the array table engine.
// Used by the controller, the datapath and the top level; no dependencies.
package ate_pkg;

  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int POS_W       = 5;
  localparam int IDX_W       = 5;
  localparam int DEF_ENTRIES = 32;
  localparam int MAX_READ    = 32;

  // Command codes carried by op.
  localparam logic [OP_W-1:0] OP_READ_ALL = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH   = 3'd3;
  localparam logic [OP_W-1:0] OP_SORT     = 3'd4;

  // Index counter actions.
  localparam logic [2:0] K_HOLD   = 3'd0;
  localparam logic [2:0] K_ZERO   = 3'd1;
  localparam logic [2:0] K_POS_P1 = 3'd2;
  localparam logic [2:0] K_TOP_M1 = 3'd3;
  localparam logic [2:0] K_INC    = 3'd4;
  localparam logic [2:0] K_DEC    = 3'd5;

  // Write address selects.
  localparam logic [1:0] WA_K_P1 = 2'd0;
  localparam logic [1:0] WA_K_M1 = 2'd1;
  localparam logic [1:0] WA_POS  = 2'd2;
  localparam logic [1:0] WA_TOP  = 2'd3;

  // Write data selects.
  localparam logic [2:0] WD_RD    = 3'd0;
  localparam logic [2:0] WD_VALUE = 3'd1;
  localparam logic [2:0] WD_ZERO  = 3'd2;
  localparam logic [2:0] WD_LO    = 3'd3;
  localparam logic [2:0] WD_CUR   = 3'd4;

  // Carried sort element actions.
  localparam logic [1:0] CUR_HOLD = 2'd0;
  localparam logic [1:0] CUR_RD   = 2'd1;
  localparam logic [1:0] CUR_HI   = 2'd2;

  // Pass counter actions.
  localparam logic [1:0] PASS_HOLD  = 2'd0;
  localparam logic [1:0] PASS_CLEAR = 2'd1;
  localparam logic [1:0] PASS_INC   = 2'd2;

  // Kinds of single result.
  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_ERR   = 2'd1;
  localparam logic [1:0] RES_FOUND = 2'd2;

  // Output register sources.
  localparam logic OUT_READ    = 1'b0;
  localparam logic OUT_PENDING = 1'b1;

  typedef struct packed {
    logic       take;
    logic [2:0] k_op;
    logic       rd_en;
    logic       we;
    logic [1:0] wa_sel;
    logic [2:0] wd_sel;
    logic [1:0] cur_op;
    logic [1:0] pass_op;
    logic       res_set;
    logic [1:0] res_kind;
    logic       out_load;
    logic       out_src;
  } ate_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_bad;
    logic            pos_top;
    logic            k_eq_pos;
    logic            k_eq_top;
    logic            k_eq_rd_last;
    logic            match;
    logic            pass_last;
    logic            out_free;
  } ate_status_t;

endpackage

>>> rtl/core/ate_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ate_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/ate_ctrl.sv
// Sequencer for the array table engine: one command at a time.
// Depends on ate_pkg for the command and status structs.
module ate_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  ate_pkg::ate_status_t sts,
  output ate_pkg::ate_cmd_t    ctl
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DISPATCH   = 4'd1;
  localparam logic [3:0] S_RD_ISSUE   = 4'd2;
  localparam logic [3:0] S_RD_WAIT    = 4'd3;
  localparam logic [3:0] S_INS_SHIFT  = 4'd4;
  localparam logic [3:0] S_INS_WRITE  = 4'd5;
  localparam logic [3:0] S_DEL_SHIFT  = 4'd6;
  localparam logic [3:0] S_DEL_FILL   = 4'd7;
  localparam logic [3:0] S_SEARCH     = 4'd8;
  localparam logic [3:0] S_SORT_START = 4'd9;
  localparam logic [3:0] S_SORT_FIRST = 4'd10;
  localparam logic [3:0] S_SORT_STEP  = 4'd11;
  localparam logic [3:0] S_SORT_TAIL  = 4'd12;
  localparam logic [3:0] S_RESP       = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.k_op     = ate_pkg::K_HOLD;
    ctl.cur_op   = ate_pkg::CUR_HOLD;
    ctl.pass_op  = ate_pkg::PASS_HOLD;
    ctl.res_kind = ate_pkg::RES_OK;
    ctl.out_src  = ate_pkg::OUT_PENDING;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.take   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          ate_pkg::OP_READ_ALL: begin
            ctl.k_op   = ate_pkg::K_ZERO;
            state_next = S_RD_ISSUE;
          end
          ate_pkg::OP_INSERT: begin
            if (sts.pos_bad) begin
              ctl.res_set  = 1'b1;
              ctl.res_kind = ate_pkg::RES_ERR;
              state_next   = S_RESP;
            end else if (sts.pos_top) begin
              state_next = S_INS_WRITE;
            end else begin
              ctl.k_op   = ate_pkg::K_TOP_M1;
              ctl.rd_en  = 1'b1;
              state_next = S_INS_SHIFT;
            end
          end
          ate_pkg::OP_DELETE: begin
            if (sts.pos_bad) begin
              ctl.res_set  = 1'b1;
              ctl.res_kind = ate_pkg::RES_ERR;
              state_next   = S_RESP;
            end else if (sts.pos_top) begin
              state_next = S_DEL_FILL;
            end else begin
              ctl.k_op   = ate_pkg::K_POS_P1;
              ctl.rd_en  = 1'b1;
              state_next = S_DEL_SHIFT;
            end
          end
          ate_pkg::OP_SEARCH: begin
            ctl.k_op   = ate_pkg::K_ZERO;
            ctl.rd_en  = 1'b1;
            state_next = S_SEARCH;
          end
          ate_pkg::OP_SORT: begin
            ctl.pass_op = ate_pkg::PASS_CLEAR;
            state_next  = S_SORT_START;
          end
          default: begin
            // Unknown commands leave the store alone and give a plain last item.
            ctl.res_set = 1'b1;
            state_next  = S_RESP;
          end
        endcase
      end
      S_RD_ISSUE: begin
        ctl.rd_en  = 1'b1;
        state_next = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_src  = ate_pkg::OUT_READ;
          if (sts.k_eq_rd_last) begin
            state_next = S_IDLE;
          end else begin
            ctl.k_op   = ate_pkg::K_INC;
            state_next = S_RD_ISSUE;
          end
        end
      end
      S_INS_SHIFT: begin
        ctl.we     = 1'b1;
        ctl.wa_sel = ate_pkg::WA_K_P1;
        ctl.wd_sel = ate_pkg::WD_RD;
        if (sts.k_eq_pos) begin
          state_next = S_INS_WRITE;
        end else begin
          ctl.k_op  = ate_pkg::K_DEC;
          ctl.rd_en = 1'b1;
        end
      end
      S_INS_WRITE: begin
        ctl.we      = 1'b1;
        ctl.wa_sel  = ate_pkg::WA_POS;
        ctl.wd_sel  = ate_pkg::WD_VALUE;
        ctl.res_set = 1'b1;
        state_next  = S_RESP;
      end
      S_DEL_SHIFT: begin
        ctl.we     = 1'b1;
        ctl.wa_sel = ate_pkg::WA_K_M1;
        ctl.wd_sel = ate_pkg::WD_RD;
        if (sts.k_eq_top) begin
          state_next = S_DEL_FILL;
        end else begin
          ctl.k_op  = ate_pkg::K_INC;
          ctl.rd_en = 1'b1;
        end
      end
      S_DEL_FILL: begin
        ctl.we      = 1'b1;
        ctl.wa_sel  = ate_pkg::WA_TOP;
        ctl.wd_sel  = ate_pkg::WD_ZERO;
        ctl.res_set = 1'b1;
        state_next  = S_RESP;
      end
      S_SEARCH: begin
        if (sts.match) begin
          ctl.res_set  = 1'b1;
          ctl.res_kind = ate_pkg::RES_FOUND;
          state_next   = S_RESP;
        end else if (sts.k_eq_top) begin
          ctl.res_set = 1'b1;
          state_next  = S_RESP;
        end else begin
          ctl.k_op  = ate_pkg::K_INC;
          ctl.rd_en = 1'b1;
        end
      end
      S_SORT_START: begin
        ctl.k_op   = ate_pkg::K_ZERO;
        ctl.rd_en  = 1'b1;
        state_next = S_SORT_FIRST;
      end
      S_SORT_FIRST: begin
        ctl.cur_op = ate_pkg::CUR_RD;
        ctl.k_op   = ate_pkg::K_INC;
        ctl.rd_en  = 1'b1;
        state_next = S_SORT_STEP;
      end
      S_SORT_STEP: begin
        // The larger of the pair is carried on up the pass.
        ctl.we     = 1'b1;
        ctl.wa_sel = ate_pkg::WA_K_M1;
        ctl.wd_sel = ate_pkg::WD_LO;
        ctl.cur_op = ate_pkg::CUR_HI;
        if (sts.k_eq_top) begin
          state_next = S_SORT_TAIL;
        end else begin
          ctl.k_op  = ate_pkg::K_INC;
          ctl.rd_en = 1'b1;
        end
      end
      S_SORT_TAIL: begin
        ctl.we     = 1'b1;
        ctl.wa_sel = ate_pkg::WA_TOP;
        ctl.wd_sel = ate_pkg::WD_CUR;
        if (sts.pass_last) begin
          ctl.res_set = 1'b1;
          state_next  = S_RESP;
        end else begin
          ctl.pass_op = ate_pkg::PASS_INC;
          state_next  = S_SORT_START;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/ate_datapath.sv
// Datapath of the array table engine: entry RAM, valid flags, counters,
// sort carry register and the result register. Depends on ate_pkg and ate_ram.
module ate_datapath #(
  parameter int ENTRIES = ate_pkg::DEF_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ate_pkg::ate_cmd_t                  ctl,
  output ate_pkg::ate_status_t               sts,
  input  logic [ate_pkg::OP_W-1:0]           op,
  input  logic [ate_pkg::POS_W-1:0]          position,
  input  logic signed [ate_pkg::DATA_W-1:0]  value,
  input  logic signed [ate_pkg::DATA_W-1:0]  search_key,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [ate_pkg::DATA_W-1:0]  entry_value,
  output logic [ate_pkg::IDX_W-1:0]          entry_index,
  output logic                               found,
  output logic                               status,
  output logic                               last
);

  localparam int AW      = $clog2(ENTRIES);
  localparam int CW      = ((AW > ate_pkg::POS_W) ? AW : ate_pkg::POS_W) + 1;
  localparam int RD_LAST = ((ENTRIES < ate_pkg::MAX_READ) ? ENTRIES : ate_pkg::MAX_READ) - 1;

  logic [ate_pkg::OP_W-1:0]          op_q;
  logic [ate_pkg::POS_W-1:0]         pos_q;
  logic signed [ate_pkg::DATA_W-1:0] value_q;
  logic signed [ate_pkg::DATA_W-1:0] key_q;

  logic [AW-1:0]                     k;
  logic [AW-1:0]                     k_next;
  logic [AW-1:0]                     pass;
  logic signed [ate_pkg::DATA_W-1:0] cur;
  logic [ENTRIES-1:0]                valid;
  logic                              rdv;
  logic [ate_pkg::DATA_W-1:0]        ram_q;
  logic signed [ate_pkg::DATA_W-1:0] rd;

  logic [1:0]                        res_kind_q;
  logic [ate_pkg::IDX_W-1:0]         res_idx_q;

  logic [CW-1:0]                     pos_ext;
  logic [AW-1:0]                     pos_addr;
  logic [AW-1:0]                     waddr;
  logic signed [ate_pkg::DATA_W-1:0] wdata;
  logic                              less;
  logic signed [ate_pkg::DATA_W-1:0] lo;
  logic signed [ate_pkg::DATA_W-1:0] hi;
  logic                              out_free;

  assign pos_ext  = CW'(pos_q);
  assign pos_addr = pos_ext[AW-1:0];

  // Entries never written since reset read as zero.
  assign rd   = rdv ? $signed(ram_q) : '0;
  assign less = rd < cur;
  assign lo   = less ? rd : cur;
  assign hi   = less ? cur : rd;

  assign out_free = !res_valid || !res_stall;

  always_comb begin
    case (ctl.k_op)
      ate_pkg::K_ZERO:   k_next = '0;
      ate_pkg::K_POS_P1: k_next = pos_addr + AW'(1);
      ate_pkg::K_TOP_M1: k_next = AW'(ENTRIES - 2);
      ate_pkg::K_INC:    k_next = k + AW'(1);
      ate_pkg::K_DEC:    k_next = k - AW'(1);
      default:           k_next = k;
    endcase
  end

  always_comb begin
    case (ctl.wa_sel)
      ate_pkg::WA_K_P1: waddr = k + AW'(1);
      ate_pkg::WA_K_M1: waddr = k - AW'(1);
      ate_pkg::WA_POS:  waddr = pos_addr;
      default:          waddr = AW'(ENTRIES - 1);
    endcase
  end

  always_comb begin
    case (ctl.wd_sel)
      ate_pkg::WD_RD:    wdata = rd;
      ate_pkg::WD_VALUE: wdata = value_q;
      ate_pkg::WD_LO:    wdata = lo;
      ate_pkg::WD_CUR:   wdata = cur;
      default:           wdata = '0;
    endcase
  end

  ate_ram #(
    .WIDTH (ate_pkg::DATA_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.rd_en),
    .raddr (k_next),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdv <= valid[k_next];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      op_q    <= op;
      pos_q   <= position;
      value_q <= value;
      key_q   <= search_key;
    end
    k <= k_next;
    case (ctl.cur_op)
      ate_pkg::CUR_RD: cur <= rd;
      ate_pkg::CUR_HI: cur <= hi;
      default:         cur <= cur;
    endcase
    case (ctl.pass_op)
      ate_pkg::PASS_CLEAR: pass <= '0;
      ate_pkg::PASS_INC:   pass <= pass + AW'(1);
      default:             pass <= pass;
    endcase
    if (ctl.res_set) begin
      res_kind_q <= ctl.res_kind;
      res_idx_q  <= ate_pkg::IDX_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      if (ctl.out_src == ate_pkg::OUT_READ) begin
        entry_value <= rd;
        entry_index <= ate_pkg::IDX_W'(k);
        found       <= 1'b0;
        status      <= 1'b0;
        last        <= (k == AW'(RD_LAST));
      end else begin
        entry_value <= '0;
        entry_index <= (res_kind_q == ate_pkg::RES_FOUND) ? res_idx_q : '0;
        found       <= (res_kind_q == ate_pkg::RES_FOUND);
        status      <= (res_kind_q == ate_pkg::RES_ERR);
        last        <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.op           = op_q;
    sts.pos_bad      = (pos_ext >= CW'(ENTRIES));
    sts.pos_top      = (pos_ext == CW'(ENTRIES - 1));
    sts.k_eq_pos     = (CW'(k) == pos_ext);
    sts.k_eq_top     = (k == AW'(ENTRIES - 1));
    sts.k_eq_rd_last = (k == AW'(RD_LAST));
    sts.match        = (rd == key_q);
    sts.pass_last    = (pass == AW'(ENTRIES - 2));
    sts.out_free     = out_free;
  end

endmodule

>>> rtl/core/array_table_engine_top.sv
// Top level of the array table engine: a store of signed entries with
// read all, insert, delete, search and sort commands.
// Depends on ate_pkg, ate_ctrl and ate_datapath.
//
// Usage: a command item (op, position, value, search_key) is taken when
// cmd_valid is high and cmd_stall is low. Only one command is worked on at
// a time; cmd_stall stays high until its last result item is loaded into
// the output register. Result items leave on res_valid / res_stall, each
// marked last on the final item of its command.
// Work per command, N = ENTRIES, is set by the single read port of the entry
// RAM (registered read):
//   read all: min(N, 32) entries, each read and then loaded out
//   insert, delete: N - position - 1 entries shift up or down
//   search:   up to N entries; unknown op or bad position: a single item
//   sort:     (N - 1) bubble passes over all N entries.
// While the receiver stalls, the result item is held and the sequencer
// waits before loading the next one; a finished result may wait while the
// next command is taken. Reset clears the store to zero at once through
// per-entry valid flags, so no clearing pass follows reset.
module array_table_engine_top #(
  parameter int ENTRIES = ate_pkg::DEF_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [ate_pkg::OP_W-1:0]           op,
  input  logic [ate_pkg::POS_W-1:0]          position,
  input  logic signed [ate_pkg::DATA_W-1:0]  value,
  input  logic signed [ate_pkg::DATA_W-1:0]  search_key,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [ate_pkg::DATA_W-1:0]  entry_value,
  output logic [ate_pkg::IDX_W-1:0]          entry_index,
  output logic                               found,
  output logic                               status,
  output logic                               last
);

  ate_pkg::ate_cmd_t    ctl;
  ate_pkg::ate_status_t sts;

  ate_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  ate_datapath #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .op          (op),
    .position    (position),
    .value       (value),
    .search_key  (search_key),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .entry_value (entry_value),
    .entry_index (entry_index),
    .found       (found),
    .status      (status),
    .last        (last)
  );

endmodule

>>> rtl/core/ate_checker.sv
// Port-level checks for the array table engine, bound to the top level.
// Depends on ate_pkg for field widths.
module ate_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_stall,
  input logic                               res_valid,
  input logic                               res_stall,
  input logic signed [ate_pkg::DATA_W-1:0]  entry_value,
  input logic [ate_pkg::IDX_W-1:0]          entry_index,
  input logic                               found,
  input logic                               status,
  input logic                               last
);

  // A stalled result item holds still.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(entry_value)
      && $stable(entry_index) && $stable(found) && $stable(status) && $stable(last))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Only single-item commands report a match or an error, and those are last.
  a_flags_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (found || status) |-> last && (entry_value == '0))
    else $error("match or error on a non-final or non-zero item");

  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && found |-> !status)
    else $error("match reported together with an error");

  // One command at a time: taking an item makes the block busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("second item taken straight after the first");

endmodule

bind array_table_engine_top ate_checker u_chk (.*);
